>>> hdl/bwa_pkg.sv
// ----------------------------------------------------------------------------
// bwa_pkg
// Shared types, codes and constants of the Boltzmann weighted average block.
// ----------------------------------------------------------------------------
package bwa_pkg;

	// item operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// result kinds
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_RANGE    = 2'd2;

	// fixed-point constants
	localparam logic [17:0] TEMP_RESET   = 18'd76326;
	localparam logic [17:0] TEMP_FLOOR   = 18'd256;
	localparam logic [9:0]  GAS_CONST    = 10'd831;      // R * 100
	localparam logic [24:0] EXP_SCALE    = 25'd25600000; // 1000 * 100 * 256
	localparam logic [16:0] LOG2E_Q16    = 17'd94548;
	localparam logic [31:0] ENERGY_MAX   = 32'h7FFF_FFFF;
	localparam int          WEIGHT_KMAX  = 17;

	// quotient lengths of the three divisions
	localparam int DIV_QW      = 32;
	localparam int X_QBITS     = 21;
	localparam int OCC_QBITS   = 17;
	localparam int AVG_QBITS   = 32;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] average;
		logic signed [31:0] minimum;
		logic [16:0]        occupancy;
		logic [10:0]        count;
		logic [1:0]         status;
	} result_t;

	// 2^(-2^-(j+1)) in Q30
	function automatic logic [29:0] exp2_factor(input logic [3:0] j);
		logic [29:0] f;
		unique case (j)
			4'd0:    f = 30'd759250125;
			4'd1:    f = 30'd902905651;
			4'd2:    f = 30'd984625594;
			4'd3:    f = 30'd1028218693;
			4'd4:    f = 30'd1050733751;
			4'd5:    f = 30'd1062175491;
			4'd6:    f = 30'd1067942999;
			4'd7:    f = 30'd1070838486;
			4'd8:    f = 30'd1072289173;
			4'd9:    f = 30'd1073015252;
			4'd10:   f = 30'd1073378477;
			4'd11:   f = 30'd1073560135;
			default: f = 30'd1073741823;
		endcase
		return f;
	endfunction

endpackage

>>> hdl/bwa_in_if.sv
// ----------------------------------------------------------------------------
// bwa_in_if
// Input item channel: valid/ready handshake with load/read payload.
// ----------------------------------------------------------------------------
interface bwa_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] energy;
	logic               last_entry;
	logic [9:0]         entry_index;

	modport source (output valid, operation, energy, last_entry, entry_index, input ready);
	modport sink   (input valid, operation, energy, last_entry, entry_index, output ready);
endinterface

>>> hdl/bwa_out_if.sv
// ----------------------------------------------------------------------------
// bwa_out_if
// Result item channel: valid/ready handshake with summary/read payload.
// ----------------------------------------------------------------------------
interface bwa_out_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic signed [31:0] average_energy;
	logic signed [31:0] minimum_energy;
	logic [16:0]        occupancy;
	logic [10:0]        entry_count;
	logic [1:0]         status;

	modport source (output valid, result_kind, average_energy, minimum_energy, occupancy,
		entry_count, status, input ready);
	modport sink   (input valid, result_kind, average_energy, minimum_energy, occupancy,
		entry_count, status, output ready);
endinterface

>>> hdl/bwa_ram.sv
// ----------------------------------------------------------------------------
// bwa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bwa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> hdl/bwa_div.sv
// ----------------------------------------------------------------------------
// bwa_div
// Restoring divider, one quotient bit per cycle, with quotient overflow flag.
// ----------------------------------------------------------------------------
module bwa_div #(
	parameter int NW = 60,
	parameter int DW = 28,
	parameter int QW = 32,
	localparam int QBW = $clog2(QW + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NW-1:0]      num,
	input  logic [DW-1:0]      den,
	input  logic [QBW-1:0]     qbits,
	output logic [QW-1:0]      quo,
	output bwa_pkg::div_stat_t stat
);
	localparam logic [QBW-1:0] QW_L = QBW'(QW);

	logic [NW-1:0]  hi;
	logic           hi_ovf;
	logic [DW:0]    shifted;
	logic           ge;
	logic [DW:0]    diff;

	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [QW-1:0]  lo_q;
	logic [QW-1:0]  quo_q;
	logic [QBW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic           ovf_q;

	assign hi      = num >> qbits;
	assign hi_ovf  = hi >= NW'(den);
	assign shifted = {rem_q, lo_q[QW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ovf_q <= hi_ovf;
				cnt_q <= qbits;
				if (hi_ovf || qbits == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QBW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi[DW-1:0];
			den_q <= den;
			lo_q  <= num[QW-1:0] << (QW_L - qbits);
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[DW-1:0] : shifted[DW-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign quo       = quo_q;
	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
endmodule

>>> hdl/boltzmann_weighted_average.sv
// ----------------------------------------------------------------------------
// boltzmann_weighted_average
// Boltzmann-weighted mean free energy of a loaded set, with occupancy reads.
// ----------------------------------------------------------------------------
// Usage:
//   request  - input items. A load (operation 0) stores one Q15.16 energy;
//              a load with last_entry set closes the set and starts the
//              computation. A read (operation 1) asks for the occupancy of
//              entry_index in the closed set.
//   response - result items: one summary after each closing load (mean,
//              minimum, count, overflow status) and one answer per read.
//   temperature_we/_wdata - temperature register, to be written only while idle; the block does not enforce this.
// Sequencing:
//   A plain load leaves the sequencer in S_IDLE, ready for the next item.
//   A read passes through S_RD_DATA and S_EMIT; its answer waits in S_EMIT
//   until the output register is free. A closing load runs two passes over
//   the energy and occupancy RAMs, one entry at a time through a shared
//   one-bit-per-cycle divider: the weight pass (subtract the minimum, divide
//   by R*T, exponentiate in EXP_TABLE_BITS table steps, weight), then the
//   normalization of each weight by the sum, then the mean division.
//   The single sequencer takes no new item until it is back in S_IDLE.
// Reset clears the count, minimum, sum, overflow and set state; RAM contents
// stay undefined and no clearing pass runs. A stalled receiver holds the
// output register; loads that give no result are still taken meanwhile.
module boltzmann_weighted_average #(
	parameter int DEPTH          = 1024,
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	bwa_in_if.sink      request,
	bwa_out_if.source   response,
	input  logic        temperature_we,
	input  logic [17:0] temperature_wdata
);
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = (CW > 10) ? CW : 10;
	localparam int SW   = $clog2(DEPTH) + 17;
	localparam int NUMW = $clog2(DEPTH) + 49;
	localparam int DNW  = (NUMW + 1 > 57) ? NUMW + 1 : 57;
	localparam int DDW  = (SW > 28) ? SW : 28;
	localparam int QBW  = $clog2(bwa_pkg::DIV_QW + 1);
	localparam int JW   = $clog2(EXP_TABLE_BITS + 1);

	typedef enum logic [17:0] {
		S_IDLE    = 18'b000000000000000001,
		S_RD_DATA = 18'b000000000000000010,
		S_E_RD    = 18'b000000000000000100,
		S_E_SUB   = 18'b000000000000001000,
		S_E_MUL   = 18'b000000000000010000,
		S_E_DIV   = 18'b000000000000100000,
		S_E_DWAIT = 18'b000000000001000000,
		S_E_Y     = 18'b000000000010000000,
		S_E_EXP   = 18'b000000000100000000,
		S_E_W     = 18'b000000001000000000,
		S_E_PROD  = 18'b000000010000000000,
		S_E_SUM   = 18'b000000100000000000,
		S_N_RD    = 18'b000001000000000000,
		S_N_DIV   = 18'b000010000000000000,
		S_N_WAIT  = 18'b000100000000000000,
		S_A_DIV   = 18'b001000000000000000,
		S_A_WAIT  = 18'b010000000000000000,
		S_EMIT    = 18'b100000000000000000
	} state_t;

	state_t state_q;

	// control state
	logic [17:0]        temp_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] min_q;
	logic [SW-1:0]      sum_q;
	logic [NUMW-1:0]    num_q;
	logic               ovf_q;
	logic               closed_q;
	logic [CW-1:0]      i_q;
	logic               out_valid_q;

	// datapath registers
	logic [31:0]                 d_q;
	logic [27:0]                 den_q;
	logic [56:0]                 n_q;
	logic [20:0]                 x_q;
	logic                        zero_q;
	logic [21:0]                 y_q;
	logic [30:0]                 acc_q;
	logic [EXP_TABLE_BITS-1:0]   idx_q;
	logic [JW-1:0]               jc_q;
	logic [16:0]                 w_q;
	logic [48:0]                 prod_q;
	logic                        rd_ok_q;
	bwa_pkg::result_t            res_q;
	bwa_pkg::result_t            out_q;

	// RAM ports
	logic          e_we;
	logic [AW-1:0] e_waddr;
	logic [31:0]   e_rdata;
	logic          o_we;
	logic [AW-1:0] o_waddr;
	logic [16:0]   o_wdata;
	logic [AW-1:0] o_raddr;
	logic [16:0]   o_rdata;

	// divider ports
	logic               div_start;
	logic [DNW-1:0]     div_num;
	logic [DDW-1:0]     div_den;
	logic [QBW-1:0]     div_qbits;
	logic [31:0]        div_quo;
	bwa_pkg::div_stat_t div_stat;

	logic               accept;
	logic [CW-1:0]      cnt_eff;
	logic signed [31:0] min_eff;
	logic               ovf_eff;
	logic               has_room;
	logic [17:0]        temp_eff;
	logic [32:0]        diff_e;
	logic [37:0]        y_full;
	logic [60:0]        acc_prod;
	logic [30:0]        acc_rnd;
	logic [16:0]        mant;
	logic [5:0]         kexp;
	logic               last_i;
	logic               out_free;

	assign accept   = request.valid && request.ready;
	assign cnt_eff  = closed_q ? '0 : count_q;
	assign min_eff  = closed_q ? $signed(bwa_pkg::ENERGY_MAX) : min_q;
	assign ovf_eff  = closed_q ? 1'b0 : ovf_q;
	assign has_room = cnt_eff < CW'(DEPTH);
	assign temp_eff = (temp_q < bwa_pkg::TEMP_FLOOR) ? bwa_pkg::TEMP_FLOOR : temp_q;
	assign diff_e   = {e_rdata[31], e_rdata} - {min_q[31], min_q};
	assign y_full   = 38'(x_q) * 38'(bwa_pkg::LOG2E_Q16);
	assign acc_prod = 61'(acc_q) * 61'(bwa_pkg::exp2_factor(4'(jc_q))) + 61'(1 << 29);
	assign acc_rnd  = acc_q + 31'(8192);
	assign mant     = acc_rnd[30:14];
	assign kexp     = y_q[21:16];
	assign last_i   = (i_q + 1'b1) == count_q;
	assign out_free = !out_valid_q || response.ready;

	assign request.ready = (state_q == S_IDLE);

	// energy RAM: written on load, read in the weight pass
	assign e_we    = accept && request.operation == bwa_pkg::OP_LOAD && has_room;
	assign e_waddr = cnt_eff[AW-1:0];

	bwa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_energy_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (request.energy),
		.raddr (i_q[AW-1:0]),
		.rdata (e_rdata)
	);

	// occupancy RAM: raw weights first, then normalized shares in place.
	// The sequencer handles one entry at a time, so a write never races a read.
	always_comb begin
		o_we    = 1'b0;
		o_wdata = w_q;
		if (state_q == S_E_PROD) begin
			o_we = 1'b1;
		end else if (state_q == S_N_WAIT && div_stat.done) begin
			o_we    = 1'b1;
			o_wdata = div_quo[16:0];
		end
	end
	assign o_waddr = i_q[AW-1:0];
	assign o_raddr = (state_q == S_IDLE) ? AW'(request.entry_index) : i_q[AW-1:0];

	bwa_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_occupancy_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	// shared divider: exponent, normalization, and weighted mean
	always_comb begin
		div_start = 1'b0;
		div_num   = DNW'(n_q);
		div_den   = DDW'(den_q);
		div_qbits = QBW'(bwa_pkg::X_QBITS);
		unique case (state_q)
			S_E_DIV: begin
				div_start = 1'b1;
			end
			S_N_DIV: begin
				div_start = 1'b1;
				div_num   = DNW'({o_rdata, 16'b0}) + DNW'(sum_q >> 1);
				div_den   = DDW'(sum_q);
				div_qbits = QBW'(bwa_pkg::OCC_QBITS);
			end
			S_A_DIV: begin
				div_start = 1'b1;
				div_num   = DNW'(num_q) + DNW'(sum_q >> 1);
				div_den   = DDW'(sum_q);
				div_qbits = QBW'(bwa_pkg::AVG_QBITS);
			end
			default: begin
			end
		endcase
	end

	bwa_div #(.NW(DNW), .DW(DDW), .QW(bwa_pkg::DIV_QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.qbits  (div_qbits),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			temp_q      <= bwa_pkg::TEMP_RESET;
			count_q     <= '0;
			min_q       <= $signed(bwa_pkg::ENERGY_MAX);
			sum_q       <= '0;
			num_q       <= '0;
			ovf_q       <= 1'b0;
			closed_q    <= 1'b0;
			i_q         <= '0;
			jc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (temperature_we) begin
				temp_q <= temperature_wdata;
			end
			// drop the output item once taken; S_EMIT reloads it on its own
			if (out_valid_q && response.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && request.operation == bwa_pkg::OP_READ) begin
						state_q <= S_RD_DATA;
					end else if (accept) begin
						// a load after a closed set opens a new one
						if (has_room) begin
							count_q <= cnt_eff + 1'b1;
							min_q   <= (request.energy < min_eff) ? request.energy : min_eff;
							ovf_q   <= ovf_eff;
						end else begin
							count_q <= cnt_eff;
							min_q   <= min_eff;
							ovf_q   <= 1'b1;
						end
						closed_q <= request.last_entry;
						if (request.last_entry) begin
							i_q     <= '0;
							sum_q   <= '0;
							num_q   <= '0;
							state_q <= S_E_RD;
						end
					end
				end
				S_RD_DATA: state_q <= S_EMIT;
				S_E_RD:    state_q <= S_E_SUB;
				S_E_SUB:   state_q <= S_E_MUL;
				S_E_MUL:   state_q <= S_E_DIV;
				S_E_DIV:   state_q <= S_E_DWAIT;
				S_E_DWAIT: begin
					if (div_stat.done) begin
						state_q <= S_E_Y;
					end
				end
				S_E_Y: begin
					jc_q    <= '0;
					state_q <= S_E_EXP;
				end
				S_E_EXP: begin
					jc_q <= jc_q + 1'b1;
					if (jc_q == JW'(EXP_TABLE_BITS - 1)) begin
						state_q <= S_E_W;
					end
				end
				S_E_W:    state_q <= S_E_PROD;
				S_E_PROD: state_q <= S_E_SUM;
				S_E_SUM: begin
					sum_q <= sum_q + SW'(w_q);
					num_q <= num_q + NUMW'(prod_q);
					if (last_i) begin
						i_q     <= '0;
						state_q <= S_N_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_E_RD;
					end
				end
				S_N_RD:  state_q <= S_N_DIV;
				S_N_DIV: state_q <= S_N_WAIT;
				S_N_WAIT: begin
					if (div_stat.done) begin
						if (last_i) begin
							state_q <= S_A_DIV;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_N_RD;
						end
					end
				end
				S_A_DIV: state_q <= S_A_WAIT;
				S_A_WAIT: begin
					if (div_stat.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					// hold the result until the output register frees up
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rd_ok_q <= closed_q && (IW'(request.entry_index) < IW'(count_q));
			end
			S_RD_DATA: begin
				res_q.kind      <= bwa_pkg::KIND_READ;
				res_q.average   <= '0;
				res_q.minimum   <= '0;
				res_q.occupancy <= rd_ok_q ? o_rdata : 17'd0;
				res_q.count     <= 11'(count_q);
				res_q.status    <= rd_ok_q ? bwa_pkg::STATUS_OK : bwa_pkg::STATUS_RANGE;
			end
			S_E_SUB: begin
				d_q   <= diff_e[31:0];
				den_q <= 28'(temp_eff) * 28'(bwa_pkg::GAS_CONST);
			end
			S_E_MUL: begin
				n_q <= 57'(d_q) * 57'(bwa_pkg::EXP_SCALE);
			end
			S_E_DWAIT: begin
				x_q    <= div_quo[20:0];
				zero_q <= div_stat.ovf;
			end
			S_E_Y: begin
				y_q   <= y_full[37:16];
				idx_q <= y_full[31:32-EXP_TABLE_BITS];
				acc_q <= 31'(1 << 30);
			end
			S_E_EXP: begin
				if (idx_q[EXP_TABLE_BITS-1]) begin
					acc_q <= acc_prod[60:30];
				end
				idx_q <= idx_q << 1;
			end
			S_E_W: begin
				w_q <= (zero_q || kexp >= 6'(bwa_pkg::WEIGHT_KMAX)) ? 17'd0 : (mant >> kexp);
			end
			S_E_PROD: begin
				prod_q <= 49'(w_q) * 49'(d_q);
			end
			S_A_WAIT: begin
				res_q.kind      <= bwa_pkg::KIND_SUMMARY;
				res_q.average   <= min_q + $signed(div_quo[31:0]);
				res_q.minimum   <= min_q;
				res_q.occupancy <= '0;
				res_q.count     <= 11'(count_q);
				res_q.status    <= ovf_q ? bwa_pkg::STATUS_OVERFLOW : bwa_pkg::STATUS_OK;
			end
			S_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign response.valid          = out_valid_q;
	assign response.result_kind    = out_q.kind;
	assign response.average_energy = out_q.average;
	assign response.minimum_energy = out_q.minimum;
	assign response.occupancy      = out_q.occupancy;
	assign response.entry_count    = out_q.count;
	assign response.status         = out_q.status;
endmodule

>>> hdl/bwa_checker.sv
// ----------------------------------------------------------------------------
// bwa_checker
// Port-level checks on result items of the weighted average block.
// ----------------------------------------------------------------------------
module bwa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        result_kind,
	input logic [31:0] average_energy,
	input logic [31:0] minimum_energy,
	input logic [16:0] occupancy,
	input logic [1:0]  status
);
	// a stalled item stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// read answers carry no energies
	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == bwa_pkg::KIND_READ |->
		average_energy == '0 && minimum_energy == '0)
		else $error("read answer carries energy fields");

	// summaries carry no occupancy and never a range error
	a_summary_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == bwa_pkg::KIND_SUMMARY |->
		occupancy == '0 && status != bwa_pkg::STATUS_RANGE)
		else $error("summary carries occupancy or range status");

	// a rejected read gives zero occupancy, reads never report overflow
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == bwa_pkg::KIND_READ |->
		(status == bwa_pkg::STATUS_OK) ||
		(status == bwa_pkg::STATUS_RANGE && occupancy == '0))
		else $error("bad read answer status");
endmodule

bind boltzmann_weighted_average bwa_checker u_bwa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (response.valid),
	.out_ready      (response.ready),
	.result_kind    (response.result_kind),
	.average_energy (response.average_energy),
	.minimum_energy (response.minimum_energy),
	.occupancy      (response.occupancy),
	.status         (response.status)
);
